// ===== rtl/fccm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fccm_pkg
// Shared sizes, codes and helpers of the cluster chain manager.
// ----------------------------------------------------------------------------
package fccm_pkg;

    localparam int TableEntries = 32768;
    localparam int AddrW        = $clog2(TableEntries);
    localparam int LinkW        = 16;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_READ    = 2'd1,
        OP_LOOKUP  = 2'd2,
        OP_REPLACE = 2'd3
    } t_op;

    localparam logic [1:0] StatusOk      = 2'd0;
    localparam logic [1:0] StatusInvalid = 2'd1;
    localparam logic [1:0] StatusNoFree  = 2'd2;

    localparam logic CfgFreeMarker = 1'b0;
    localparam logic CfgEndMarker  = 1'b1;

    localparam logic [LinkW-1:0] FreeMarkerReset = 16'hFFFE;
    localparam logic [LinkW-1:0] EndMarkerReset  = 16'hFFFB;

    function automatic logic in_table(input logic [LinkW-1:0] v);
        return ({16'b0, v} < 32'(TableEntries));
    endfunction

    function automatic logic index_ok(input logic [14:0] v);
        return ({17'b0, v} < 32'(TableEntries));
    endfunction

endpackage

// ===== rtl/fccm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fccm_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module fccm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fat_chain_cluster_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_cluster_manager
// Allocation table of next-cluster links with chain lookup and replacement.
//
// An item is taken when start is high and busy is low. Busy falls in the
// cycle in which the result is shown, so the next item can be taken at the
// edge that takes the result. Each item gives one result, shown for a single
// cycle with o_valid high. The receiver cannot stall, so a result is never
// held. Configuration writes are taken at any edge with i_cfg_we high.
// Steps from acceptance to the result:
//   load entry: the write at acceptance. Read entry: a RAM read and its wait.
//   chain lookup: one RAM read and its wait for each hop.
//   replace/append: a free scan that reads one entry per cycle up to the
//   first free index, then (position - 1) hops and the update states
//   ST_PREV_WT, ST_RD_OLD, ST_WR_FRESH and ST_WR_OLD, or ST_RD_OLD onward
//   at position 0. Without an old cluster ST_WR_OLD is skipped. A scan over
//   a table with no free entry reads every entry, then answers StatusNoFree.
// Reset returns the marker registers to their defaults and the control to
// idle; the table itself is not cleared and must be loaded first.
// ----------------------------------------------------------------------------
module fat_chain_cluster_manager (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_op,
    input  logic [14:0]               i_entry_index,
    input  logic [15:0]               i_entry_value,
    input  logic [15:0]               i_chain_head,
    input  logic [15:0]               i_chain_position,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [15:0]               i_cfg_wdata,
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic [15:0]               o_cluster_out,
    output logic [15:0]               o_new_head,
    output logic                      o_freed_valid,
    output logic [14:0]               o_freed_cluster
);

    localparam int AW = fccm_pkg::AddrW;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_RD_WAIT  = 10'b00_0000_0010,
        ST_SCAN     = 10'b00_0000_0100,
        ST_WALK     = 10'b00_0000_1000,
        ST_WALK_WT  = 10'b00_0001_0000,
        ST_PREV_WT  = 10'b00_0010_0000,
        ST_RD_OLD   = 10'b00_0100_0000,
        ST_WR_FRESH = 10'b00_1000_0000,
        ST_WR_OLD   = 10'b01_0000_0000,
        ST_SPARE    = 10'b10_0000_0000
    } t_state;

    t_state          r_state, n_state;
    fccm_pkg::t_op   r_op, n_op;
    logic [15:0]     r_head, n_head;
    logic [15:0]     r_pos, n_pos;
    logic [15:0]     r_cur, n_cur;
    logic [15:0]     r_cnt, n_cnt;
    logic [15:0]     r_old, n_old;
    logic [AW-1:0]   r_fresh, n_fresh;
    logic [AW-1:0]   r_prev, n_prev;
    logic [AW:0]     r_scan, n_scan;
    logic            r_scan_vld, n_scan_vld;
    logic [AW-1:0]   r_scan_tag, n_scan_tag;
    logic [15:0]     r_free_mk, r_end_mk;

    logic            r_valid, n_valid;
    logic [1:0]      r_status, n_status;
    logic [15:0]     r_cluster, n_cluster;
    logic [15:0]     r_new_head, n_new_head;
    logic            r_freed_valid, n_freed_valid;
    logic [14:0]     r_freed_cluster, n_freed_cluster;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [15:0]     ram_wdata, ram_rdata;
    logic            accept;
    logic            old_in;

    fccm_ram #(
        .WIDTH (16),
        .DEPTH (fccm_pkg::TableEntries)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept = start && (r_state == ST_IDLE);
    assign old_in = fccm_pkg::in_table(r_old);

    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        n_head          = r_head;
        n_pos           = r_pos;
        n_cur           = r_cur;
        n_cnt           = r_cnt;
        n_old           = r_old;
        n_fresh         = r_fresh;
        n_prev          = r_prev;
        n_scan          = r_scan;
        n_scan_vld      = 1'b0;
        n_scan_tag      = r_scan_tag;
        n_valid         = 1'b0;
        n_status        = r_status;
        n_cluster       = r_cluster;
        n_new_head      = r_new_head;
        n_freed_valid   = r_freed_valid;
        n_freed_cluster = r_freed_cluster;
        ram_we          = 1'b0;
        ram_waddr       = r_fresh;
        ram_wdata       = 16'd0;
        ram_re          = 1'b0;
        ram_raddr       = r_cur[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op   = fccm_pkg::t_op'(i_op);
                    n_head = i_chain_head;
                    n_pos  = i_chain_position;
                    n_cur  = i_chain_head;
                    n_new_head      = i_chain_head;
                    n_status        = fccm_pkg::StatusInvalid;
                    n_cluster       = 16'd0;
                    n_freed_valid   = 1'b0;
                    n_freed_cluster = 15'd0;
                    case (fccm_pkg::t_op'(i_op))
                        fccm_pkg::OP_LOAD: begin
                            n_valid = 1'b1;
                            if (fccm_pkg::index_ok(i_entry_index)) begin
                                ram_we    = 1'b1;
                                ram_waddr = i_entry_index[AW-1:0];
                                ram_wdata = i_entry_value;
                                n_status  = fccm_pkg::StatusOk;
                                n_cluster = i_entry_value;
                            end
                        end
                        fccm_pkg::OP_READ: begin
                            if (fccm_pkg::index_ok(i_entry_index)) begin
                                ram_re    = 1'b1;
                                ram_raddr = i_entry_index[AW-1:0];
                                n_state   = ST_RD_WAIT;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        fccm_pkg::OP_LOOKUP: begin
                            n_cnt   = i_chain_position;
                            n_state = ST_WALK;
                        end
                        fccm_pkg::OP_REPLACE: begin
                            n_cnt   = (i_chain_position == 16'd0) ? 16'd0
                                                                  : i_chain_position - 16'd1;
                            n_scan  = '0;
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                n_valid   = 1'b1;
                n_status  = fccm_pkg::StatusOk;
                n_cluster = ram_rdata;
                n_state   = ST_IDLE;
            end
            ST_SCAN: begin
                if (r_scan_vld && (ram_rdata == r_free_mk)) begin
                    n_fresh = r_scan_tag;
                    n_state = ST_WALK;
                end else if (r_scan == (AW+1)'(fccm_pkg::TableEntries)) begin
                    if (!r_scan_vld) begin
                        n_valid  = 1'b1;
                        n_status = fccm_pkg::StatusNoFree;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = r_scan[AW-1:0];
                    n_scan_vld = 1'b1;
                    n_scan_tag = r_scan[AW-1:0];
                    n_scan     = r_scan + 1'b1;
                end
            end
            ST_WALK: begin
                if (r_cnt != 16'd0) begin
                    if (fccm_pkg::in_table(r_cur)) begin
                        ram_re  = 1'b1;
                        n_state = ST_WALK_WT;
                    end else begin
                        n_valid = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else if (r_op == fccm_pkg::OP_LOOKUP) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                    if (fccm_pkg::in_table(r_cur)) begin
                        n_status  = fccm_pkg::StatusOk;
                        n_cluster = r_cur;
                    end
                end else if (r_pos == 16'd0) begin
                    n_old   = r_head;
                    n_state = ST_RD_OLD;
                end else if (fccm_pkg::in_table(r_cur)) begin
                    ram_re  = 1'b1;
                    n_prev  = r_cur[AW-1:0];
                    n_state = ST_PREV_WT;
                end else begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_WALK_WT: begin
                n_cur   = ram_rdata;
                n_cnt   = r_cnt - 16'd1;
                n_state = ST_WALK;
            end
            ST_PREV_WT: begin
                n_old     = ram_rdata;
                ram_we    = 1'b1;
                ram_waddr = r_prev;
                ram_wdata = 16'(r_fresh);
                n_state   = ST_RD_OLD;
            end
            ST_RD_OLD: begin
                ram_re    = old_in;
                ram_raddr = r_old[AW-1:0];
                n_state   = ST_WR_FRESH;
            end
            ST_WR_FRESH: begin
                ram_we    = 1'b1;
                ram_waddr = r_fresh;
                ram_wdata = old_in ? ram_rdata : r_end_mk;
                n_status  = fccm_pkg::StatusOk;
                n_cluster = 16'(r_fresh);
                if (r_pos == 16'd0) begin
                    n_new_head = 16'(r_fresh);
                end
                if (old_in) begin
                    n_state = ST_WR_OLD;
                end else begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_WR_OLD: begin
                ram_we          = 1'b1;
                ram_waddr       = r_old[AW-1:0];
                ram_wdata       = r_free_mk;
                n_valid         = 1'b1;
                n_freed_valid   = 1'b1;
                n_freed_cluster = r_old[14:0];
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= 1'b0;
            r_scan_vld <= 1'b0;
            r_free_mk  <= fccm_pkg::FreeMarkerReset;
            r_end_mk   <= fccm_pkg::EndMarkerReset;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_scan_vld <= n_scan_vld;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fccm_pkg::CfgFreeMarker: r_free_mk <= i_cfg_wdata;
                    fccm_pkg::CfgEndMarker:  r_end_mk  <= i_cfg_wdata;
                    default: begin
                        r_free_mk <= r_free_mk;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op            <= n_op;
        r_head          <= n_head;
        r_pos           <= n_pos;
        r_cur           <= n_cur;
        r_cnt           <= n_cnt;
        r_old           <= n_old;
        r_fresh         <= n_fresh;
        r_prev          <= n_prev;
        r_scan          <= n_scan;
        r_scan_tag      <= n_scan_tag;
        r_status        <= n_status;
        r_cluster       <= n_cluster;
        r_new_head      <= n_new_head;
        r_freed_valid   <= n_freed_valid;
        r_freed_cluster <= n_freed_cluster;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_cluster_out   = r_cluster;
    assign o_new_head      = r_new_head;
    assign o_freed_valid   = r_freed_valid;
    assign o_freed_cluster = r_freed_cluster;

endmodule

// ===== test/tb_fat_chain_cluster_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fat_chain_cluster_manager
// Self-checking bench for the cluster chain manager. The whole link table is
// loaded first, then a short directed sequence covers loads, reads, chain
// lookups, replacement and appending, marker heads, broken chains,
// overlapping links and a table with no free entry. Five phases of random
// items with different marker settings follow. A shadow copy of the table
// predicts every result, and each result is compared field by field.
// ----------------------------------------------------------------------------

typedef struct packed {
    fccm_pkg::t_op op;
    logic [14:0]   index;
    logic [15:0]   value;
    logic [15:0]   head;
    logic [15:0]   position;
} t_cluster_cmd;

typedef struct packed {
    logic [1:0]  status;
    logic [15:0] cluster;
    logic [15:0] head;
    logic        freed;
    logic [14:0] freed_cluster;
} t_cluster_result;

class t_link_table_shadow;
    logic [15:0]     links [fccm_pkg::TableEntries];
    logic [15:0]     free_mark;
    logic [15:0]     end_mark;
    t_cluster_result awaited [$];
    int              mismatch_count;

    function new();
        free_mark      = fccm_pkg::FreeMarkerReset;
        end_mark       = fccm_pkg::EndMarkerReset;
        mismatch_count = 0;
    endfunction

    function void set_marker(input logic index, input logic [15:0] value);
        if (index == fccm_pkg::CfgFreeMarker) begin
            free_mark = value;
        end else begin
            end_mark = value;
        end
    endfunction

    function bit follow_chain(input logic [15:0] head, input int hops,
                              output logic [15:0] found);
        logic [15:0] cur;
        int          k;
        cur = head;
        for (k = 0; k < hops; k++) begin
            if (cur >= fccm_pkg::TableEntries) return 1'b0;
            cur = links[cur[14:0]];
        end
        if (cur >= fccm_pkg::TableEntries) return 1'b0;
        found = cur;
        return 1'b1;
    endfunction

    function int chain_exit_hop(input logic [15:0] head, input int limit);
        logic [15:0] cur;
        int          k;
        cur = head;
        for (k = 0; k <= limit; k++) begin
            if (cur >= fccm_pkg::TableEntries) return k;
            cur = links[cur[14:0]];
        end
        return limit + 1;
    endfunction

    function int first_free();
        int k;
        for (k = 0; k < fccm_pkg::TableEntries; k++) begin
            if (links[k] == free_mark) return k;
        end
        return fccm_pkg::TableEntries;
    endfunction

    function logic [15:0] absent_value();
        int  c;
        int  k;
        bit  seen;
        for (c = 32768; c < 65536; c++) begin
            seen = 1'b0;
            for (k = 0; k < fccm_pkg::TableEntries && !seen; k++) begin
                if (links[k] == 16'(c)) seen = 1'b1;
            end
            if (!seen) return 16'(c);
        end
        return 16'hFFFF;
    endfunction

    function void apply_command(input t_cluster_cmd cmd);
        t_cluster_result r;
        logic [15:0]     found;
        logic [15:0]     old;
        logic [15:0]     prev;
        int              fresh;
        bit              have_old;
        bit              ok;
        r.status        = fccm_pkg::StatusInvalid;
        r.cluster       = '0;
        r.head          = cmd.head;
        r.freed         = 1'b0;
        r.freed_cluster = '0;
        case (cmd.op)
            fccm_pkg::OP_LOAD: begin
                links[cmd.index] = cmd.value;
                r.status  = fccm_pkg::StatusOk;
                r.cluster = cmd.value;
            end
            fccm_pkg::OP_READ: begin
                r.status  = fccm_pkg::StatusOk;
                r.cluster = links[cmd.index];
            end
            fccm_pkg::OP_LOOKUP: begin
                if (follow_chain(cmd.head, int'(cmd.position), found)) begin
                    r.status  = fccm_pkg::StatusOk;
                    r.cluster = found;
                end
            end
            default: begin
                fresh = first_free();
                if (fresh == fccm_pkg::TableEntries) begin
                    r.status = fccm_pkg::StatusNoFree;
                end else begin
                    have_old = follow_chain(cmd.head, int'(cmd.position), old);
                    ok = 1'b1;
                    if (cmd.position != 0) begin
                        ok = follow_chain(cmd.head, int'(cmd.position) - 1, prev);
                    end
                    if (ok) begin
                        if (cmd.position == 0) begin
                            r.head = 16'(fresh);
                        end else begin
                            links[prev[14:0]] = 16'(fresh);
                        end
                        links[fresh] = have_old ? links[old[14:0]] : end_mark;
                        if (have_old) begin
                            links[old[14:0]] = free_mark;
                            r.freed          = 1'b1;
                            r.freed_cluster  = old[14:0];
                        end
                        r.status  = fccm_pkg::StatusOk;
                        r.cluster = 16'(fresh);
                    end
                end
            end
        endcase
        awaited.push_back(r);
    endfunction

    function void compare_result(input t_cluster_result got);
        t_cluster_result want;
        if (awaited.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("unexpected result: status %0d cluster %h head %h",
                         got.status, got.cluster, got.head);
            end
            return;
        end
        want = awaited.pop_front();
        if (got.status !== want.status || got.cluster !== want.cluster ||
            got.head !== want.head || got.freed !== want.freed ||
            got.freed_cluster !== want.freed_cluster) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("result mismatch (expected/actual): status %0d/%0d cluster %h/%h",
                         want.status, got.status, want.cluster, got.cluster);
                $display("    head %h/%h freed %0d/%0d freed cluster %h/%h",
                         want.head, got.head, want.freed, got.freed,
                         want.freed_cluster, got.freed_cluster);
            end
        end
    endfunction

    function int pending();
        return awaited.size();
    endfunction
endclass

module tb_fat_chain_cluster_manager;

    localparam int LowSpan = 512;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        start            = 1'b0;
    logic        busy;
    logic [1:0]  i_op             = '0;
    logic [14:0] i_entry_index    = '0;
    logic [15:0] i_entry_value    = '0;
    logic [15:0] i_chain_head     = '0;
    logic [15:0] i_chain_position = '0;
    logic        i_cfg_we         = 1'b0;
    logic        i_cfg_index      = 1'b0;
    logic [15:0] i_cfg_wdata      = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_cluster_out;
    logic [15:0] o_new_head;
    logic        o_freed_valid;
    logic [14:0] o_freed_cluster;

    t_link_table_shadow shadow;

    fat_chain_cluster_manager u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_entry_index    (i_entry_index),
        .i_entry_value    (i_entry_value),
        .i_chain_head     (i_chain_head),
        .i_chain_position (i_chain_position),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_cluster_out    (o_cluster_out),
        .o_new_head       (o_new_head),
        .o_freed_valid    (o_freed_valid),
        .o_freed_cluster  (o_freed_cluster)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            shadow.compare_result(t_cluster_result'{o_status, o_cluster_out, o_new_head,
                                                    o_freed_valid, o_freed_cluster});
        end
    end

    function automatic t_cluster_cmd make_cmd(input fccm_pkg::t_op op,
                                              input logic [14:0] index,
                                              input logic [15:0] value,
                                              input logic [15:0] head,
                                              input logic [15:0] position);
        t_cluster_cmd c;
        c.op       = op;
        c.index    = index;
        c.value    = value;
        c.head     = head;
        c.position = position;
        return c;
    endfunction

    function automatic t_cluster_cmd random_cmd();
        t_cluster_cmd c;
        int           sel;
        c.index    = ($urandom_range(0, 4) == 0) ? 15'($urandom)
                                                 : 15'($urandom_range(0, LowSpan - 1));
        c.value    = 16'($urandom);
        c.head     = 16'($urandom);
        c.position = 16'($urandom_range(0, 6));
        sel = $urandom_range(0, 19);
        if (sel < 6) begin
            c.op = fccm_pkg::OP_LOAD;
            sel = $urandom_range(0, 9);
            if (sel < 3) begin
                c.value = shadow.free_mark;
            end else if (sel < 5) begin
                c.value = shadow.end_mark;
            end else if (sel < 9) begin
                c.value = 16'($urandom_range(0, LowSpan - 1));
            end
        end else if (sel < 9) begin
            c.op = fccm_pkg::OP_READ;
        end else begin
            c.op = (sel < 14) ? fccm_pkg::OP_LOOKUP : fccm_pkg::OP_REPLACE;
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                c.head = 16'($urandom_range(0, LowSpan - 1));
            end else if (sel == 7) begin
                c.head = $urandom_range(0, 1) ? shadow.free_mark : shadow.end_mark;
            end
            if ($urandom_range(0, 4) == 0) begin
                c.position = 16'($urandom);
                if (shadow.chain_exit_hop(c.head, 40) > 40) begin
                    c.position = 16'($urandom_range(0, 6));
                end
            end
            if (c.op == fccm_pkg::OP_REPLACE && shadow.first_free() >= 1024) begin
                c.op    = fccm_pkg::OP_LOAD;
                c.index = 15'($urandom_range(0, 255));
                c.value = shadow.free_mark;
            end
        end
        return c;
    endfunction

    task automatic issue(input t_cluster_cmd cmd);
        start            <= 1'b1;
        i_op             <= cmd.op;
        i_entry_index    <= cmd.index;
        i_entry_value    <= cmd.value;
        i_chain_head     <= cmd.head;
        i_chain_position <= cmd.position;
        do @(posedge i_clk); while (busy);
        shadow.apply_command(cmd);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (shadow.pending() != 0 || busy);
    endtask

    task automatic write_markers(input logic [15:0] free_value,
                                 input logic [15:0] end_value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= fccm_pkg::CfgFreeMarker;
        i_cfg_wdata <= free_value;
        @(posedge i_clk);
        shadow.set_marker(fccm_pkg::CfgFreeMarker, free_value);
        i_cfg_index <= fccm_pkg::CfgEndMarker;
        i_cfg_wdata <= end_value;
        @(posedge i_clk);
        shadow.set_marker(fccm_pkg::CfgEndMarker, end_value);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic load_whole_table();
        logic [15:0] v;
        int          k;
        for (k = 0; k < fccm_pkg::TableEntries; k++) begin
            if (k < LowSpan) begin
                case ($urandom_range(0, 3))
                    0:       v = shadow.free_mark;
                    1:       v = shadow.end_mark;
                    default: v = 16'($urandom_range(0, LowSpan - 1));
                endcase
            end else if ($urandom_range(0, 3) == 0) begin
                v = 16'($urandom);
                if (v == shadow.free_mark) v = shadow.end_mark;
            end else begin
                v = shadow.end_mark;
            end
            issue(make_cmd(fccm_pkg::OP_LOAD, 15'(k), v, 16'($urandom), 16'($urandom)));
        end
    endtask

    task automatic run_directed();
        issue(make_cmd(fccm_pkg::OP_LOAD, 15'h7FFF, 16'hFFFF, 16'h0000, 16'h0000));
        issue(make_cmd(fccm_pkg::OP_READ, 15'h7FFF, 16'h0000, 16'hFFFF, 16'hFFFF));
        issue(make_cmd(fccm_pkg::OP_LOAD, 15'd0, 16'h0000, 16'h0000, 16'h0000));
        issue(make_cmd(fccm_pkg::OP_READ, 15'd0, 16'hFFFF, 16'h0000, 16'h0000));
        issue(make_cmd(fccm_pkg::OP_LOAD, 15'd20, 16'd21, 16'h0000, 16'h0000));
        issue(make_cmd(fccm_pkg::OP_LOAD, 15'd21, 16'd22, 16'h0000, 16'h0000));
        issue(make_cmd(fccm_pkg::OP_LOAD, 15'd22, shadow.end_mark, 16'h0000, 16'h0000));
        issue(make_cmd(fccm_pkg::OP_LOAD, 15'd3, shadow.free_mark, 16'h0000, 16'h0000));
        issue(make_cmd(fccm_pkg::OP_LOAD, 15'd4, shadow.free_mark, 16'h0000, 16'h0000));
        issue(make_cmd(fccm_pkg::OP_LOAD, 15'd5, shadow.free_mark, 16'h0000, 16'h0000));
        issue(make_cmd(fccm_pkg::OP_LOAD, 15'd6, shadow.free_mark, 16'h0000, 16'h0000));
        issue(make_cmd(fccm_pkg::OP_LOOKUP, 15'd0, 16'h0000, 16'd20, 16'd0));
        issue(make_cmd(fccm_pkg::OP_LOOKUP, 15'd0, 16'h0000, 16'd20, 16'd2));
        issue(make_cmd(fccm_pkg::OP_LOOKUP, 15'd0, 16'h0000, 16'd20, 16'd3));
        issue(make_cmd(fccm_pkg::OP_LOOKUP, 15'd0, 16'h0000, 16'd20, 16'hFFFF));
        issue(make_cmd(fccm_pkg::OP_LOOKUP, 15'd0, 16'h0000, shadow.end_mark, 16'd0));
        issue(make_cmd(fccm_pkg::OP_LOOKUP, 15'd0, 16'h0000, 16'hFFFF, 16'd0));
        issue(make_cmd(fccm_pkg::OP_LOOKUP, 15'd0, 16'h0000, 16'h7FFF, 16'd1));
        issue(make_cmd(fccm_pkg::OP_REPLACE, 15'd0, 16'h0000, 16'd20, 16'd1));
        issue(make_cmd(fccm_pkg::OP_REPLACE, 15'd0, 16'h0000, 16'd20, 16'd3));
        issue(make_cmd(fccm_pkg::OP_REPLACE, 15'd0, 16'h0000, 16'd20, 16'd0));
        issue(make_cmd(fccm_pkg::OP_REPLACE, 15'd0, 16'h0000, shadow.end_mark, 16'd0));
        issue(make_cmd(fccm_pkg::OP_REPLACE, 15'd0, 16'h0000, 16'd20, 16'd10));
        issue(make_cmd(fccm_pkg::OP_REPLACE, 15'd0, 16'h0000, 16'hFFFF, 16'hFFFF));
        issue(make_cmd(fccm_pkg::OP_REPLACE, 15'd0, 16'h0000, 16'd0, 16'd1));
    endtask

    task automatic run_phase(input int count);
        int sent;
        int burst;
        int k;
        int gap_kind;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (k = 0; k < burst && sent < count; k++) begin
                issue(random_cmd());
                sent++;
            end
            gap_kind = $urandom_range(0, 9);
            if (gap_kind == 0) begin
                wait_drained();
            end else if (gap_kind > 3) begin
                pause_sender($urandom_range(1, 20));
            end
        end
    endtask

    initial begin : stimulus
        logic [15:0] free_set [5];
        logic [15:0] end_set [5];
        int          p;
        shadow   = new();
        free_set = '{16'hFFFE, 16'h8000, 16'hFFFF, 16'h8000, 16'hC000};
        end_set  = '{16'hFFFB, 16'hFFFF, 16'h8000, 16'h8000, 16'hC000};
        free_set[3] = 16'($urandom_range(32768, 65535));
        end_set[3]  = 16'($urandom_range(32768, 65535));
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        load_whole_table();
        run_directed();
        wait_drained();
        write_markers(shadow.absent_value(), shadow.end_mark);
        issue(make_cmd(fccm_pkg::OP_REPLACE, 15'd0, 16'h0000, 16'd20, 16'd0));
        for (p = 0; p < 5; p++) begin
            wait_drained();
            write_markers(free_set[p], end_set[p]);
            run_phase(100);
        end
        start <= 1'b0;
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (shadow.mismatch_count == 0 && shadow.pending() == 0) begin
            $display("fat_chain_cluster_manager test passed");
        end else begin
            $display("fat_chain_cluster_manager test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("fat_chain_cluster_manager test failed");
        $finish;
    end

endmodule

// ===== fat_chain_cluster_manager.f =====
rtl/fccm_pkg.sv
rtl/fccm_ram.sv
rtl/fat_chain_cluster_manager.sv
test/tb_fat_chain_cluster_manager.sv
